FILE: hw/rtl/crf_pkg.sv
// crf_pkg: shared constants for the centripetal radius fit block.
// Used by crf_sqrt, crf_div and the top level; depends on nothing.
package crf_pkg;

   // Default fraction bits of every fixed-point value
   localparam int FRAC_BITS_DEF = 16;

   // round(pi/180000 * 2^40): mdps Q8 to rad/s
   localparam logic [31:0] OMEGA_K = 32'd19190098;
   // round(9.81/1000 * 2^32): mg Q16 to m/s^2
   localparam logic [31:0] ACC_K = 32'd42133629;

   // Configuration register indexes
   localparam int CSR_AW = 2;
   localparam int CSR_DW = 16;
   localparam logic [CSR_AW-1:0] CSR_OMEGA_MIN  = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_GRAVITY_MG = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_ACCEL_MIN  = 2'd2;
   localparam logic [CSR_AW-1:0] CSR_MIN_POINTS = 2'd3;

   // Configuration reset values
   localparam logic [15:0] OMEGA_MIN_RST  = 16'd19661;
   localparam logic [13:0] GRAVITY_MG_RST = 14'd1000;
   localparam logic [13:0] ACCEL_MIN_RST  = 14'd50;
   localparam logic [7:0]  MIN_POINTS_RST = 8'd3;

   // Stream widths
   localparam int REQ_W = 112;
   localparam int RSP_W = 120;

   // Iterative unit sizes
   localparam int SQRT_STEPS = 32;

   // Handshake between the sequencer and an iterative unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

FILE: hw/rtl/crf_mul.sv
// crf_mul: shared 32x32 unsigned multiplier with registered product.
// Uses no package items; driven by the sequencer in the top level.
module crf_mul (
   input  logic        clock,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [63:0] product
);

   logic [63:0] prod_ff;
   logic [63:0] prod_in;

   // Multiply the presented operands
   assign prod_in = 64'(op_a) * 64'(op_b);

   // Register the product for the next cycle
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

FILE: hw/rtl/crf_sqrt.sv
// crf_sqrt: integer square root of a 64-bit value, one root bit per cycle.
// Depends on crf_pkg for the step count and the status struct.
module crf_sqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [63:0]            radicand,
   output crf_pkg::unit_stat_type stat,
   output logic [31:0]            root
);

   logic [63:0] x_ff, x_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   logic [35:0] rem_sh;
   logic [35:0] trial;
   logic [35:0] diff;
   logic        fits;

   // Bring down two radicand bits and try the next root bit
   assign rem_sh = {rem_ff, x_ff[63:62]};
   assign trial  = {2'b00, root_ff, 2'b01};
   assign diff   = rem_sh - trial;
   assign fits   = rem_sh >= trial;

   always_comb begin
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         x_in    = {x_ff[61:0], 2'b00};
         rem_in  = fits ? diff[33:0] : rem_sh[33:0];
         root_in = {root_ff[30:0], fits};
         cnt_in  = cnt_ff + 5'd1;
         if (cnt_ff == 5'(crf_pkg::SQRT_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign root      = root_ff;

endmodule

FILE: hw/rtl/crf_div.sv
// crf_div: restoring divider giving floor(numer * 2^FRAC_BITS / denom),
// saturated to 32 bits, one quotient bit per cycle. Depends on crf_pkg.
module crf_div #(
   parameter int FRAC_BITS = crf_pkg::FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [63:0]            numer,
   input  logic [63:0]            denom,
   output crf_pkg::unit_stat_type stat,
   output logic [31:0]            quot
);

   localparam int STEPS = 64 + FRAC_BITS;
   localparam int CW    = $clog2(STEPS);

   logic [63:0]   dvd_ff, dvd_in;
   logic [63:0]   den_ff, den_in;
   logic [63:0]   rem_ff, rem_in;
   logic [31:0]   q_ff, q_in;
   logic          sat_ff, sat_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   logic [64:0] rem_sh;
   logic [64:0] diff;
   logic        fits;

   // Shift in the next dividend bit and compare against the divisor
   assign rem_sh = {rem_ff, dvd_ff[63]};
   assign diff   = rem_sh - {1'b0, den_ff};
   assign fits   = rem_sh >= {1'b0, den_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      sat_in  = sat_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = numer;
         den_in  = denom;
         rem_in  = '0;
         q_in    = '0;
         sat_in  = 1'b0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[62:0], 1'b0};
         rem_in = fits ? diff[63:0] : rem_sh[63:0];
         // a bit pushed out of the top means the quotient is 2^32 or more
         sat_in = sat_ff | q_ff[31];
         q_in   = {q_ff[30:0], fits};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      sat_ff <= sat_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = sat_ff ? 32'hFFFF_FFFF : q_ff;

endmodule

FILE: hw/rtl/centripetal_radius_fit_core.sv
// centripetal_radius_fit_core: top level of the centripetal radius fit.
// Depends on crf_pkg, crf_mul, crf_sqrt and crf_div.

// Each request is one inertial sample and produces exactly one response. A
// small sequencer runs every product through one shared 32x32 multiplier
// (states S_MUL_A and S_MUL_B, seventeen products at most), takes at most two
// square roots on a one-bit-per-cycle unit and ends with a restoring divide.
// A sample that a gate rejects skips the fit products and the sum updates;
// one with a zero or negative radicand is rejected without the second root.
// While the fit denominator is still zero the divide is skipped. req_tready is
// low while a sample is in work. A finished response waits in an output
// register while the next request is taken.
module centripetal_radius_fit_core #(
   parameter int FRAC_BITS = crf_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // request: accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [crf_pkg::REQ_W-1:0]   req_tdata,
   // request: start_of_run
   input  logic                        req_tuser,
   // response: accepted, omega, accel_c, radius, point_count,
   // radius_valid, sum_overflow
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [crf_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                        csr_we,
   input  logic [crf_pkg::CSR_AW-1:0]  csr_addr,
   input  logic [crf_pkg::CSR_DW-1:0]  csr_wdata
);

   localparam int OM_SH = 48 - FRAC_BITS;
   localparam logic [79:0] RND = 80'(1) << (47 - FRAC_BITS);

   typedef enum logic [3:0] {
      S_IDLE, S_MUL_A, S_MUL_B, S_SQG_START, S_SQRT_G, S_SQA_START, S_SQRT_A,
      S_GATE, S_SUM_A, S_SUM_W, S_DIV_START, S_DIV, S_OUT
   } state_type;

   typedef enum logic [4:0] {
      OP_GX, OP_GY, OP_GZ, OP_OMK, OP_AX, OP_AY, OP_AZ, OP_GRAV, OP_AMIN,
      OP_ACK, OP_WW, OP_W4_LL, OP_W4_LH, OP_W4_HL, OP_W4_HH, OP_AW_L, OP_AW_H
   } op_type;

   // Configuration
   logic [15:0] omega_min_ff;
   logic [13:0] gravity_ff;
   logic [13:0] amin_ff;
   logic [7:0]  minpts_ff;

   // Sequencer and sample registers
   state_type   state_ff, state_in;
   op_type      op_ff, op_in;
   logic [14:0] ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   logic [21:0] gx_ff, gx_in, gy_ff, gy_in, gz_ff, gz_in;
   logic [127:0] acc_ff, acc_in;
   logic signed [31:0] rad_ff, rad_in;
   logic [27:0] amin2_ff, amin2_in;
   logic [31:0] omega_ff, omega_in;
   logic [31:0] accel_ff, accel_in;
   logic [63:0] w2_ff, w2_in;
   logic [63:0] w4_ff, w4_in;
   logic [63:0] aw2_ff, aw2_in;
   logic        accepted_ff, accepted_in;
   logic [31:0] radius_ff, radius_in;

   // Running fit state
   logic [63:0] sum_a_ff, sum_a_in;
   logic [63:0] sum_w_ff, sum_w_in;
   logic [15:0] points_ff, points_in;
   logic        ovf_ff, ovf_in;

   // Response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [crf_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;

   // Shared units
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic        sq_start;
   logic [63:0] sq_x;
   crf_pkg::unit_stat_type sq_stat;
   logic [31:0] sq_root;
   logic        dv_start;
   crf_pkg::unit_stat_type dv_stat;
   logic [31:0] dv_quot;

   // Datapath helpers
   logic [21:0]  gx_abs, gy_abs, gz_abs;
   logic [14:0]  ax_abs, ay_abs, az_abs;
   logic [6:0]   acc_shift;
   logic [127:0] acc_sum;
   logic [127:0] acc_frac;
   logic [63:0]  acc_sat;
   logic [79:0]  rnd_sum;
   logic [79:0]  scaled;
   logic [64:0]  sum_a_add;
   logic [64:0]  sum_w_add;
   logic         omega_ok;
   logic         rad_pass;
   logic         req_fire;

   crf_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   crf_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_x),
      .stat     (sq_stat),
      .root     (sq_root)
   );

   crf_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (dv_start),
      .numer (sum_a_ff),
      .denom (sum_w_ff),
      .stat  (dv_stat),
      .quot  (dv_quot)
   );

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         omega_min_ff <= crf_pkg::OMEGA_MIN_RST;
         gravity_ff   <= crf_pkg::GRAVITY_MG_RST;
         amin_ff      <= crf_pkg::ACCEL_MIN_RST;
         minpts_ff    <= crf_pkg::MIN_POINTS_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            crf_pkg::CSR_OMEGA_MIN:  omega_min_ff <= csr_wdata;
            crf_pkg::CSR_GRAVITY_MG: gravity_ff   <= csr_wdata[13:0];
            crf_pkg::CSR_ACCEL_MIN:  amin_ff      <= csr_wdata[13:0];
            crf_pkg::CSR_MIN_POINTS: minpts_ff    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Absolute values of the sample axes
   assign gx_abs = gx_ff[21] ? 22'(-gx_ff) : gx_ff;
   assign gy_abs = gy_ff[21] ? 22'(-gy_ff) : gy_ff;
   assign gz_abs = gz_ff[21] ? 22'(-gz_ff) : gz_ff;
   assign ax_abs = ax_ff[14] ? 15'(-ax_ff) : ax_ff;
   assign ay_abs = ay_ff[14] ? 15'(-ay_ff) : ay_ff;
   assign az_abs = az_ff[14] ? 15'(-az_ff) : az_ff;

   // Select multiplier operands for the current product
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (op_ff)
         OP_GX:    begin mul_a = 32'(gx_abs);    mul_b = 32'(gx_abs);    end
         OP_GY:    begin mul_a = 32'(gy_abs);    mul_b = 32'(gy_abs);    end
         OP_GZ:    begin mul_a = 32'(gz_abs);    mul_b = 32'(gz_abs);    end
         OP_OMK:   begin mul_a = sq_root;        mul_b = crf_pkg::OMEGA_K; end
         OP_AX:    begin mul_a = 32'(ax_abs);    mul_b = 32'(ax_abs);    end
         OP_AY:    begin mul_a = 32'(ay_abs);    mul_b = 32'(ay_abs);    end
         OP_AZ:    begin mul_a = 32'(az_abs);    mul_b = 32'(az_abs);    end
         OP_GRAV:  begin mul_a = 32'(gravity_ff); mul_b = 32'(gravity_ff); end
         OP_AMIN:  begin mul_a = 32'(amin_ff);   mul_b = 32'(amin_ff);   end
         OP_ACK:   begin mul_a = sq_root;        mul_b = crf_pkg::ACC_K; end
         OP_WW:    begin mul_a = omega_ff;       mul_b = omega_ff;       end
         OP_W4_LL: begin mul_a = w2_ff[31:0];    mul_b = w2_ff[31:0];    end
         OP_W4_LH: begin mul_a = w2_ff[31:0];    mul_b = w2_ff[63:32];   end
         OP_W4_HL: begin mul_a = w2_ff[63:32];   mul_b = w2_ff[31:0];    end
         OP_W4_HH: begin mul_a = w2_ff[63:32];   mul_b = w2_ff[63:32];   end
         OP_AW_L:  begin mul_a = accel_ff;       mul_b = w2_ff[31:0];    end
         OP_AW_H:  begin mul_a = accel_ff;       mul_b = w2_ff[63:32];   end
         default:  begin mul_a = '0;             mul_b = '0;             end
      endcase
   end

   // Place a partial product at its weight and add it to the accumulator
   always_comb begin
      if (op_ff == OP_W4_HH) begin
         acc_shift = 7'd64;
      end else if (op_ff == OP_W4_LH || op_ff == OP_W4_HL || op_ff == OP_AW_H) begin
         acc_shift = 7'd32;
      end else begin
         acc_shift = 7'd0;
      end
   end
   assign acc_sum  = acc_ff + (128'(mul_p) << acc_shift);
   assign acc_frac = acc_sum >> FRAC_BITS;
   assign acc_sat  = (|acc_frac[127:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : acc_frac[63:0];

   // Round and scale a unit-conversion product
   assign rnd_sum = 80'(mul_p) + RND;
   assign scaled  = rnd_sum >> OM_SH;

   // Gates and saturating sums
   assign omega_ok  = {omega_ff, 16'h0000} >= (48'(omega_min_ff) << FRAC_BITS);
   assign rad_pass  = rad_ff > $signed({4'h0, amin2_ff});
   assign sum_a_add = {1'b0, sum_a_ff} + {1'b0, aw2_ff};
   assign sum_w_add = {1'b0, sum_w_ff} + {1'b0, w4_ff};

   // Start the iterative units
   assign sq_start = (state_ff == S_SQG_START) || (state_ff == S_SQA_START);
   assign sq_x     = (state_ff == S_SQG_START) ? {4'h0, acc_ff[43:0], 16'h0000}
                                               : {1'b0, rad_ff[30:0], 32'h0000_0000};
   assign dv_start = (state_ff == S_DIV_START) && (sum_w_ff != '0);

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      az_in        = az_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      gz_in        = gz_ff;
      acc_in       = acc_ff;
      rad_in       = rad_ff;
      amin2_in     = amin2_ff;
      omega_in     = omega_ff;
      accel_in     = accel_ff;
      w2_in        = w2_ff;
      w4_in        = w4_ff;
      aw2_in       = aw2_ff;
      accepted_in  = accepted_ff;
      radius_in    = radius_ff;
      sum_a_in     = sum_a_ff;
      sum_w_in     = sum_w_ff;
      points_in    = points_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // drop the response once it is taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               ax_in = req_tdata[14:0];
               ay_in = req_tdata[29:15];
               az_in = req_tdata[44:30];
               gx_in = req_tdata[66:45];
               gy_in = req_tdata[88:67];
               gz_in = req_tdata[110:89];
               // clear the run before this sample
               if (req_tuser) begin
                  sum_a_in  = '0;
                  sum_w_in  = '0;
                  points_in = '0;
                  ovf_in    = 1'b0;
               end
               accepted_in = 1'b0;
               op_in       = OP_GX;
               state_in    = S_MUL_A;
            end
         end
         S_MUL_A: begin
            state_in = S_MUL_B;
         end
         S_MUL_B: begin
            state_in = S_MUL_A;
            unique case (op_ff)
               OP_GX:   begin acc_in = 128'(mul_p); op_in = OP_GY; end
               OP_GY:   begin acc_in = acc_sum;     op_in = OP_GZ; end
               OP_GZ: begin
                  acc_in   = acc_sum;
                  state_in = S_SQG_START;
               end
               OP_OMK: begin
                  omega_in = scaled[31:0];
                  op_in    = OP_AX;
               end
               OP_AX:   begin acc_in = 128'(mul_p); op_in = OP_AY; end
               OP_AY:   begin acc_in = acc_sum;     op_in = OP_AZ; end
               OP_AZ:   begin acc_in = acc_sum;     op_in = OP_GRAV; end
               OP_GRAV: begin
                  rad_in = $signed(acc_ff[31:0] - mul_p[31:0]);
                  op_in  = OP_AMIN;
               end
               OP_AMIN: begin
                  amin2_in = mul_p[27:0];
                  // a negative or zero radicand gives no centripetal part
                  if (rad_ff > 0) begin
                     state_in = S_SQA_START;
                  end else begin
                     accel_in = '0;
                     state_in = S_GATE;
                  end
               end
               OP_ACK: begin
                  accel_in = (|scaled[79:32]) ? 32'hFFFF_FFFF : scaled[31:0];
                  state_in = S_GATE;
               end
               OP_WW: begin
                  w2_in = mul_p >> FRAC_BITS;
                  op_in = OP_W4_LL;
               end
               OP_W4_LL: begin acc_in = 128'(mul_p); op_in = OP_W4_LH; end
               OP_W4_LH: begin acc_in = acc_sum;     op_in = OP_W4_HL; end
               OP_W4_HL: begin acc_in = acc_sum;     op_in = OP_W4_HH; end
               OP_W4_HH: begin
                  w4_in = acc_sat;
                  op_in = OP_AW_L;
               end
               OP_AW_L: begin acc_in = 128'(mul_p); op_in = OP_AW_H; end
               OP_AW_H: begin
                  aw2_in   = acc_sat;
                  state_in = S_SUM_A;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_SQG_START: begin
            state_in = S_SQRT_G;
         end
         S_SQRT_G: begin
            if (sq_stat.done) begin
               op_in    = OP_OMK;
               state_in = S_MUL_A;
            end
         end
         S_SQA_START: begin
            state_in = S_SQRT_A;
         end
         S_SQRT_A: begin
            if (sq_stat.done) begin
               op_in    = OP_ACK;
               state_in = S_MUL_A;
            end
         end
         S_GATE: begin
            accepted_in = omega_ok && rad_pass;
            if (omega_ok && rad_pass) begin
               op_in    = OP_WW;
               state_in = S_MUL_A;
            end else begin
               state_in = S_DIV_START;
            end
         end
         S_SUM_A: begin
            if (sum_a_add[64]) begin
               sum_a_in = '1;
               ovf_in   = 1'b1;
            end else begin
               sum_a_in = sum_a_add[63:0];
            end
            state_in = S_SUM_W;
         end
         S_SUM_W: begin
            if (sum_w_add[64]) begin
               sum_w_in = '1;
               ovf_in   = 1'b1;
            end else begin
               sum_w_in = sum_w_add[63:0];
            end
            if (points_ff != 16'hFFFF) begin
               points_in = points_ff + 16'd1;
            end
            state_in = S_DIV_START;
         end
         S_DIV_START: begin
            if (sum_w_ff != '0) begin
               state_in = S_DIV;
            end else begin
               radius_in = '0;
               state_in  = S_OUT;
            end
         end
         S_DIV: begin
            if (dv_stat.done) begin
               radius_in = dv_quot;
               state_in  = S_OUT;
            end
         end
         S_OUT: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'b00000,
                               ovf_ff,
                               (points_ff >= 16'(minpts_ff)) && (sum_w_ff != '0),
                               points_ff,
                               radius_ff,
                               accel_ff,
                               omega_ff,
                               accepted_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_GX;
         rsp_valid_ff <= 1'b0;
         sum_a_ff     <= '0;
         sum_w_ff     <= '0;
         points_ff    <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_a_ff     <= sum_a_in;
         sum_w_ff     <= sum_w_in;
         points_ff    <= points_in;
         ovf_ff       <= ovf_in;
      end
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      az_ff       <= az_in;
      gx_ff       <= gx_in;
      gy_ff       <= gy_in;
      gz_ff       <= gz_in;
      acc_ff      <= acc_in;
      rad_ff      <= rad_in;
      amin2_ff    <= amin2_in;
      omega_ff    <= omega_in;
      accel_ff    <= accel_in;
      w2_ff       <= w2_in;
      w4_ff       <= w4_in;
      aw2_ff      <= aw2_in;
      accepted_ff <= accepted_in;
      radius_ff   <= radius_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // A reported overflow means a sum is pinned at full scale
   a_ovf_pinned: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (sum_a_ff == '1 || sum_w_ff == '1))
      else $error("overflow flag set with no saturated sum");

   // The divider never starts on a zero denominator or while it is busy
   a_div_den: assert property (@(posedge clock) disable iff (reset)
      dv_start |-> (sum_w_ff != '0 && !dv_stat.busy))
      else $error("divide started with zero denominator or busy unit");

   // The root unit is idle whenever a new root is started
   a_sqrt_idle: assert property (@(posedge clock) disable iff (reset)
      sq_start |-> !sq_stat.busy)
      else $error("square root started while busy");

   // A rejected sample leaves the sums untouched as it leaves the gate state
   a_reject_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GATE && !(omega_ok && rad_pass)) |=>
         (sum_a_ff == $past(sum_a_ff) && sum_w_ff == $past(sum_w_ff)))
      else $error("sums changed on a rejected sample");
`endif

endmodule

FILE: tb/crf_fit_checker.sv
// crf_fit_checker: watches the request, response and register ports of the
// centripetal radius fit core, predicts every response and compares it.
// Depends on crf_pkg for stream widths, register indexes, reset values and constants.
module crf_fit_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
   input  logic [crf_pkg::REQ_W-1:0]   req_tdata,
   // start_of_run
   input  logic                        req_tuser,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // accepted, omega, accel_c, radius, point_count, radius_valid, sum_overflow
   input  logic [crf_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                        csr_we,
   input  logic [crf_pkg::CSR_AW-1:0]  csr_addr,
   input  logic [crf_pkg::CSR_DW-1:0]  csr_wdata,
   output int                          mismatches,
   output int                          pending,
   output int                          fits_accepted,
   output int                          fits_valid,
   output int                          radius_saturated
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned M32 = 64'hFFFF_FFFF;
   localparam int FB = crf_pkg::FRAC_BITS_DEF;

   // last field in the lowest bits, as on rsp_tdata
   typedef struct packed {
      logic        sum_overflow;
      logic        radius_valid;
      logic [15:0] point_count;
      logic [31:0] radius;
      logic [31:0] accel_c;
      logic [31:0] omega;
      logic        accepted;
   } fit_result_type;

   // register copies
   logic [15:0] omega_min;
   logic [13:0] gravity_mg;
   logic [13:0] accel_min_mg;
   logic [7:0]  min_points;

   // running fit state
   longint unsigned sum_a_w2, sum_w4;
   logic [15:0]     points;
   logic            overflow_seen;

   fit_result_type expected_fits[$];

   assign pending = expected_fits.size();

   // bitwise square root, floor
   function automatic longint unsigned root_floor(input longint unsigned x);
      longint unsigned r, trial;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
         trial = r | (64'd1 << i);
         if (trial * trial <= x) r = trial;
      end
      return r;
   endfunction

   // (a*b) >> FB, saturated to 64 bits
   function automatic longint unsigned prod_shift(input longint unsigned a,
                                                  input longint unsigned b);
      logic [127:0] p;
      p = ({64'd0, a} * {64'd0, b}) >> FB;
      return (p[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
   endfunction

   function automatic longint unsigned add_sat(input longint unsigned a,
                                               input longint unsigned b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s[64]) begin
         overflow_seen = 1'b1;
         return 64'hFFFF_FFFF_FFFF_FFFF;
      end
      return s[63:0];
   endfunction

   // advance the fit by one sample and form its response
   function automatic fit_result_type predict_fit(input logic [crf_pkg::REQ_W-1:0] d,
                                                  input logic sor);
      fit_result_type r;
      longint ax, ay, az, gx, gy, gz, rad;
      longint unsigned g2, mdps, omega, acm, accel_c, w2, w4, aw2;
      logic [127:0] q;
      ax = longint'($signed(d[14:0]));
      ay = longint'($signed(d[29:15]));
      az = longint'($signed(d[44:30]));
      gx = longint'($signed(d[66:45]));
      gy = longint'($signed(d[88:67]));
      gz = longint'($signed(d[110:89]));
      if (sor) begin
         sum_a_w2 = 0;
         sum_w4 = 0;
         points = 0;
         overflow_seen = 1'b0;
      end
      g2 = gx * gx + gy * gy + gz * gz;
      mdps = root_floor(g2 << 16);
      omega = ((mdps * crf_pkg::OMEGA_K + (64'd1 << (47 - FB))) >> (48 - FB)) & M32;
      rad = ax * ax + ay * ay + az * az - longint'(gravity_mg) * longint'(gravity_mg);
      accel_c = 0;
      if (rad > 0) begin
         acm = root_floor(longint'(rad) << 32);
         accel_c = (acm * crf_pkg::ACC_K + (64'd1 << (47 - FB))) >> (48 - FB);
         if (accel_c > M32) accel_c = M32;
      end
      r.accepted = (omega >= longint'(omega_min) << (FB - 16)) &&
                   (rad > longint'(accel_min_mg) * longint'(accel_min_mg));
      if (r.accepted) begin
         w2 = (omega * omega) >> FB;
         w4 = prod_shift(w2, w2);
         aw2 = prod_shift(accel_c, w2);
         sum_a_w2 = add_sat(sum_a_w2, aw2);
         sum_w4 = add_sat(sum_w4, w4);
         if (points != 16'hFFFF) points++;
      end
      r.radius = 0;
      if (sum_w4 != 0) begin
         q = ({64'd0, sum_a_w2} << FB) / {64'd0, sum_w4};
         r.radius = (q > M32) ? 32'hFFFF_FFFF : q[31:0];
      end
      r.omega = omega[31:0];
      r.accel_c = accel_c[31:0];
      r.point_count = points;
      r.radius_valid = (points >= 16'(min_points)) && (sum_w4 != 0);
      r.sum_overflow = overflow_seen;
      return r;
   endfunction

   always @(posedge clock) begin
      fit_result_type exp_r, got;
      if (reset) begin
         omega_min <= crf_pkg::OMEGA_MIN_RST;
         gravity_mg <= crf_pkg::GRAVITY_MG_RST;
         accel_min_mg <= crf_pkg::ACCEL_MIN_RST;
         min_points <= crf_pkg::MIN_POINTS_RST;
         sum_a_w2 = 0;
         sum_w4 = 0;
         points = 0;
         overflow_seen = 1'b0;
         mismatches = 0;
         fits_accepted = 0;
         fits_valid = 0;
         radius_saturated = 0;
         expected_fits.delete();
      end else begin
         // track register writes
         if (csr_we) begin
            case (csr_addr)
               crf_pkg::CSR_OMEGA_MIN:  omega_min <= csr_wdata;
               crf_pkg::CSR_GRAVITY_MG: gravity_mg <= csr_wdata[13:0];
               crf_pkg::CSR_ACCEL_MIN:  accel_min_mg <= csr_wdata[13:0];
               crf_pkg::CSR_MIN_POINTS: min_points <= csr_wdata[7:0];
               default: ;
            endcase
         end
         // predict on each accepted request
         if (req_tvalid && req_tready) begin
            exp_r = predict_fit(req_tdata, req_tuser);
            expected_fits.push_back(exp_r);
            if (exp_r.accepted) fits_accepted++;
            if (exp_r.radius_valid) fits_valid++;
            if (exp_r.radius == 32'hFFFF_FFFF) radius_saturated++;
         end
         // compare each response with the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[114:0];
            if (expected_fits.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: response with nothing expected: %h", $realtime, got);
            end else begin
               exp_r = expected_fits.pop_front();
               if (got !== exp_r) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: response mismatch", $realtime);
                     $display("  exp acc=%b omega=%h accel_c=%h radius=%h cnt=%0d vld=%b ovf=%b",
                              exp_r.accepted, exp_r.omega, exp_r.accel_c, exp_r.radius,
                              exp_r.point_count, exp_r.radius_valid, exp_r.sum_overflow);
                     $display("  got acc=%b omega=%h accel_c=%h radius=%h cnt=%0d vld=%b ovf=%b",
                              got.accepted, got.omega, got.accel_c, got.radius,
                              got.point_count, got.radius_valid, got.sum_overflow);
                  end
               end
            end
         end
      end
   end

endmodule

FILE: tb/testbench.sv
// testbench: drives IMU samples and register settings into the centripetal
// radius fit core and gives the verdict. Depends on crf_pkg, the core and crf_fit_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_RANDOM = 930;
   localparam longint CYCLE_LIMIT = 2_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [crf_pkg::REQ_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [crf_pkg::RSP_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [crf_pkg::CSR_AW-1:0] csr_addr = '0;
   logic [crf_pkg::CSR_DW-1:0] csr_wdata = '0;

   int mismatches, pending, fits_accepted, fits_valid, radius_saturated;
   int send_idle_pct = 10;
   int recv_idle_pct = 69;
   int samples_sent = 0;
   longint cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   centripetal_radius_fit_core i_dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_we, .csr_addr, .csr_wdata
   );

   crf_fit_checker i_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_we, .csr_addr, .csr_wdata,
      .mismatches, .pending, .fits_accepted, .fits_valid, .radius_saturated
   );

   // stall the response side at random
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // guard against a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycles, pending);
         $display("== FAIL ==");
         $finish;
      end
   end

   // send one sample, holding it until the core takes it
   task automatic send_sample(input int ax, ay, az, gx, gy, gz, input bit sor);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= sor;
      req_tdata <= {1'b0, 22'(gz), 22'(gy), 22'(gx), 15'(az), 15'(ay), 15'(ax)};
      do @(posedge clock); while (!req_tready);
      samples_sent++;
   endtask

   // drop valid and hold until every response is back
   task automatic drain;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (20) @(posedge clock);
   endtask

   // write all four registers back to back; junk goes above each field narrower than the bus
   task automatic write_regs(input logic [15:0] om, input logic [13:0] gm,
                             input logic [13:0] am, input logic [7:0] mp);
      logic [15:0] vals[4];
      vals[crf_pkg::CSR_OMEGA_MIN] = om;
      vals[crf_pkg::CSR_GRAVITY_MG] = {2'($urandom), gm};
      vals[crf_pkg::CSR_ACCEL_MIN] = {2'($urandom), am};
      vals[crf_pkg::CSR_MIN_POINTS] = {8'($urandom), mp};
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_addr <= crf_pkg::CSR_AW'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   function automatic int rnd_signed(input int lim);
      return int'($urandom_range(2 * lim)) - lim;
   endfunction

   // one random sample, mostly rotating well-formed data with some rejects
   task automatic send_random;
      int a[3], g[3], kind;
      kind = $urandom_range(9);
      for (int i = 0; i < 3; i++) begin
         case (kind)
            0, 1, 2: begin
               a[i] = rnd_signed(16000);
               g[i] = rnd_signed(2000000);
            end
            3, 4, 5, 6: begin
               a[i] = rnd_signed(3000);
               g[i] = rnd_signed(300000);
            end
            7: begin
               a[i] = rnd_signed(3000);
               g[i] = rnd_signed(15000);
            end
            8: begin
               a[i] = rnd_signed(700);
               g[i] = rnd_signed(2000000);
            end
            default: begin
               a[i] = ($urandom_range(1)) ? 16000 : -16000;
               g[i] = ($urandom_range(1)) ? 2000000 : -2000000;
               if ($urandom_range(2) == 0) a[i] = 0;
               if ($urandom_range(2) == 0) g[i] = 0;
            end
         endcase
      end
      send_sample(a[0], a[1], a[2], g[0], g[1], g[2], $urandom_range(24) == 0);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, both gates on each side, run restart
      send_sample(0, 0, 0, 0, 0, 0, 1'b0);
      send_sample(16000, 16000, 16000, 2000000, 2000000, 2000000, 1'b0);
      send_sample(-16000, -16000, -16000, -2000000, -2000000, -2000000, 1'b0);
      send_sample(16000, -16000, 0, 2000000, 0, -2000000, 1'b0);
      send_sample(1000, 0, 0, 500000, 0, 0, 1'b0);
      send_sample(300, 200, 100, 500000, 0, 0, 1'b0);
      send_sample(1000, 50, 0, 500000, 0, 0, 1'b0);
      send_sample(1001, 50, 0, 500000, 0, 0, 1'b0);
      send_sample(3000, 0, 0, 17190, 0, 0, 1'b0);
      send_sample(3000, 0, 0, 17180, 0, 0, 1'b0);
      send_sample(0, 3000, 0, 0, 17200, 0, 1'b1);
      send_sample(-2000, 1500, 0, 0, 0, -900000, 1'b0);
      send_sample(0, 0, -16000, 0, -2000000, 0, 1'b0);
      send_sample(2500, 0, 0, 100000, 100000, 0, 1'b1);
      send_sample(2500, 0, 0, 0, 0, 0, 1'b0);
      send_sample(-1, -1, -1, -1, -1, -1, 1'b0);

      for (int n = 0; n < N_RANDOM; n++) begin
         // idling regime by progress
         if (n == N_RANDOM / 3) begin
            send_idle_pct = 69;
            recv_idle_pct = 10;
         end else if (n == 2 * N_RANDOM / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // register settings change only with the core idle
         if (n == 180) begin
            drain;
            write_regs(16'd0, 14'd0, 14'd0, 8'd1);
         end else if (n == 360) begin
            drain;
            write_regs(16'hFFFF, 14'd16000, 14'd16000, 8'd255);
         end else if (n == 460 || n == 620) begin
            drain;
            write_regs(16'($urandom_range(40000)), 14'($urandom_range(1500)),
                       14'($urandom_range(800)), 8'($urandom_range(1, 20)));
         end else if (n == 780) begin
            drain;
            write_regs(crf_pkg::OMEGA_MIN_RST, crf_pkg::GRAVITY_MG_RST,
                       crf_pkg::ACCEL_MIN_RST, crf_pkg::MIN_POINTS_RST);
         end
         send_random();
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (200) @(posedge clock);

      $display("sent %0d samples over five register settings: %0d entered the fit,",
               samples_sent, fits_accepted);
      $display("%0d with a valid radius, %0d with a saturated radius, %0d mismatches",
               fits_valid, radius_saturated, mismatches);
      if (mismatches == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/crf_pkg.sv
hw/rtl/crf_mul.sv
hw/rtl/crf_sqrt.sv
hw/rtl/crf_div.sv
hw/rtl/centripetal_radius_fit_core.sv
tb/crf_fit_checker.sv
tb/testbench.sv
